>>> hdl/cpcf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cross peak clip filter.
// No dependencies; used by scope in every hdl/ file except cpcf_ram.sv.
package cpcf_pkg;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

    // Result coordinates on the output channel
    localparam int POS_W = 10;

    // Result slots produced by one pixel, in delivery order
    localparam int RES_N     = 3;
    localparam int SLOT_PREV = 0;   // pixel of the row above, same column
    localparam int SLOT_LAG  = 1;   // last row: pixel one column back
    localparam int SLOT_LAST = 2;   // last row: final pixel of the frame

    // Neighbourhood qualifiers worked out when a pixel is taken in
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic r_lt_rows;
        logic c_ge1;
        logic c_ge2;
        logic rt_ok;
        logic last_row;
        logic row_end;
    } t_nbr_flags;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             frame_end;
    } t_pos;

endpackage

>>> hdl/cpcf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input and result output.
// Depends on cpcf_pkg for the coordinate width.
interface cpcf_pix_if #(
    parameter int PIXEL_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface cpcf_res_if #(
    parameter int PIXEL_BITS = 16
) ();
    logic                       valid;
    logic                       ready;
    logic [cpcf_pkg::POS_W-1:0] out_row;
    logic [cpcf_pkg::POS_W-1:0] out_col;
    logic [PIXEL_BITS-1:0]      pixel_out;
    logic                       frame_end;

    modport source (output valid, output out_row, output out_col, output pixel_out,
                    output frame_end, input ready);
    modport sink   (input valid, input out_row, input out_col, input pixel_out,
                    input frame_end, output ready);
endinterface

>>> hdl/cpcf_ram.sv
`timescale 1ns / 1ps
// Generic simple RAM: one write port, two read ports with registered data.
// No dependencies.
module cpcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write, and register both reads (old data on a same-address collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hdl/cpcf_kernel.sv
`timescale 1ns / 1ps
// Clip kernel: the three possible results of one input pixel and their valid mask.
// Depends on cpcf_pkg for the qualifier struct and slot order.
module cpcf_kernel #(
    parameter int PIXEL_BITS = 16
) (
    input  cpcf_pkg::t_nbr_flags          i_flags,
    input  logic [PIXEL_BITS-1:0]         i_pix,
    input  logic [PIXEL_BITS-1:0]         i_old_c,
    input  logic [PIXEL_BITS-1:0]         i_pri_c,
    input  logic [PIXEL_BITS-1:0]         i_pri_n,
    input  logic [PIXEL_BITS-1:0]         i_left,
    input  logic [PIXEL_BITS-1:0]         i_rec0,
    input  logic [PIXEL_BITS-1:0]         i_rec1,
    output logic [cpcf_pkg::RES_N-1:0]    o_valid,
    output logic [PIXEL_BITS-1:0]         o_pix [cpcf_pkg::RES_N]
);

    localparam logic [PIXEL_BITS-1:0] ZERO = '0;

    // Clip v to the largest non-zero neighbour when v exceeds it
    function automatic logic [PIXEL_BITS-1:0] clip4(
        input logic [PIXEL_BITS-1:0] v,
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input logic [PIXEL_BITS-1:0] c,
        input logic [PIXEL_BITS-1:0] d
    );
        logic [PIXEL_BITS-1:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        if (d > m) m = d;
        if ((m != ZERO) && (v > m)) return m;
        return v;
    endfunction

    // Row above: centre from the prior line, below is the incoming pixel
    always_comb begin
        o_pix[cpcf_pkg::SLOT_PREV] = clip4(i_pri_c,
                                           i_flags.r_ge2     ? i_old_c : ZERO,
                                           i_flags.r_lt_rows ? i_pix   : ZERO,
                                           i_flags.c_ge1     ? i_left  : ZERO,
                                           i_flags.rt_ok     ? i_pri_n : ZERO);
        // Last row, one column back: the incoming pixel is its right neighbour
        o_pix[cpcf_pkg::SLOT_LAG]  = clip4(i_rec0,
                                           i_flags.r_ge1 ? i_left : ZERO,
                                           ZERO,
                                           i_flags.c_ge2 ? i_rec1 : ZERO,
                                           i_pix);
        // Final pixel of the frame: only up and left remain
        o_pix[cpcf_pkg::SLOT_LAST] = clip4(i_pix,
                                           i_flags.r_ge1 ? i_pri_c : ZERO,
                                           ZERO,
                                           i_flags.c_ge1 ? i_rec0 : ZERO,
                                           ZERO);
    end

    always_comb begin
        o_valid                      = '0;
        o_valid[cpcf_pkg::SLOT_PREV] = i_flags.r_ge1;
        o_valid[cpcf_pkg::SLOT_LAG]  = i_flags.last_row && i_flags.c_ge1;
        o_valid[cpcf_pkg::SLOT_LAST] = i_flags.last_row && i_flags.row_end;
    end

endmodule

>>> hdl/cpcf_outq.sv
`timescale 1ns / 1ps
// Result slots: hold the results of one pixel and deliver them in order.
// Depends on cpcf_pkg and the cpcf_res_if interface.
module cpcf_outq #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [cpcf_pkg::RES_N-1:0] i_valid,
    input  cpcf_pkg::t_pos             i_pos [cpcf_pkg::RES_N],
    input  logic [PIXEL_BITS-1:0]      i_pix [cpcf_pkg::RES_N],
    output logic                       o_free,
    cpcf_res_if.source                 o_res
);

    logic [cpcf_pkg::RES_N-1:0] r_valid;
    logic [cpcf_pkg::RES_N-1:0] n_valid;
    logic [cpcf_pkg::RES_N-1:0] w_head;
    logic [cpcf_pkg::RES_N-1:0] w_left;
    logic                       w_take;
    cpcf_pkg::t_pos             r_pos [cpcf_pkg::RES_N];
    logic [PIXEL_BITS-1:0]      r_pix [cpcf_pkg::RES_N];
    cpcf_pkg::t_pos             w_head_pos;

    // Lowest occupied slot goes out first
    assign w_head = r_valid & (~r_valid + 1'b1);
    assign w_take = o_res.valid && o_res.ready;
    assign w_left = r_valid & ~(w_take ? w_head : '0);
    assign o_free = (w_left == '0);
    assign n_valid = i_load ? i_valid : w_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture a new set of results
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pos <= i_pos;
            r_pix <= i_pix;
        end
    end

    // Drive the head slot onto the channel
    always_comb begin
        w_head_pos      = r_pos[0];
        o_res.pixel_out = r_pix[0];
        for (int i = 1; i < cpcf_pkg::RES_N; i++) begin
            if (w_head[i]) begin
                w_head_pos      = r_pos[i];
                o_res.pixel_out = r_pix[i];
            end
        end
    end

    assign o_res.valid     = |r_valid;
    assign o_res.out_row   = w_head_pos.row;
    assign o_res.out_col   = w_head_pos.col;
    assign o_res.frame_end = w_head_pos.frame_end;

endmodule

>>> hdl/cross_peak_clip_filter.sv
`timescale 1ns / 1ps
// Cross peak clip filter: clips each pixel of a raster-order frame to the
// largest non-zero of its four neighbours when it is strictly above it.
// Channels: i_pix takes one pixel per transaction; o_res gives results with
// row, column and a frame_end mark on the last result of the frame.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write frame_rows (index 0) and
// frame_cols (index 1); zero or oversize values are saturated into range.
// Row r-1 is delivered while row r arrives; on the last row each pixel yields
// the result one column back, and the final pixel also yields its own.
// Path: input stage, then result slots, then o_res. Throughput: one pixel per
// cycle while o_res is ready and each pixel yields one result; on the last row
// a pixel yields up to two results and the final pixel up to three, and input
// waits while the single output channel drains the result slots. The line
// buffers are one dual-read RAM read once per pixel.
// Reset: position counters return to the frame start, both sizes become 1;
// line buffer contents are not cleared and never reach a result of a
// well-formed frame.
// Stall: results hold on o_res while ready is low; i_pix.ready drops while the
// input stage is occupied and the result slots do not empty in that cycle.
// Depends on cpcf_pkg, cpcf_if, cpcf_ram, cpcf_kernel and cpcf_outq.
module cross_peak_clip_filter #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cpcf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cpcf_pkg::CFG_W-1:0]     i_cfg_data,
    cpcf_pix_if.sink                       i_pix,
    cpcf_res_if.source                     o_res
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCMP_W = (COL_W + 1 > cpcf_pkg::CFG_W) ? COL_W + 1 : cpcf_pkg::CFG_W;
    localparam int RCMP_W = (ROW_W + 1 > cpcf_pkg::CFG_W) ? ROW_W + 1 : cpcf_pkg::CFG_W;
    localparam logic [CCMP_W-1:0] COLS_LIM = CCMP_W'(MAX_COLS);
    localparam logic [RCMP_W-1:0] ROWS_LIM = RCMP_W'(MAX_ROWS);

    // Configuration and position
    logic [cpcf_pkg::CFG_W-1:0] r_frame_rows;
    logic [cpcf_pkg::CFG_W-1:0] r_frame_cols;
    logic [ROW_W-1:0]           r_row_cnt;
    logic [COL_W-1:0]           r_col_cnt;
    logic [ROW_W-1:0]           n_row_cnt;
    logic [COL_W-1:0]           n_col_cnt;

    logic [RCMP_W-1:0]          w_rows;
    logic [CCMP_W-1:0]          w_cols;
    logic [RCMP_W-1:0]          w_row_p1;
    logic [CCMP_W-1:0]          w_col_p1;
    cpcf_pkg::t_nbr_flags       w_flags;
    logic                       w_in_acc;

    // Input stage
    logic                       r_a_valid;
    cpcf_pkg::t_nbr_flags       r_a_flags;
    logic [ROW_W-1:0]           r_a_row;
    logic [COL_W-1:0]           r_a_col;
    logic [PIXEL_BITS-1:0]      r_a_pix;
    logic                       w_a_adv;

    // Same-edge write forwarding
    logic                       r_fwd_a;
    logic                       r_fwd_b;
    logic [PIXEL_BITS-1:0]      r_fwd_old;
    logic [PIXEL_BITS-1:0]      r_fwd_pri;

    // Row history
    logic [PIXEL_BITS-1:0]      r_left;
    logic [PIXEL_BITS-1:0]      r_rec0;
    logic [PIXEL_BITS-1:0]      r_rec1;

    logic [2*PIXEL_BITS-1:0]    w_ram_a;
    logic [2*PIXEL_BITS-1:0]    w_ram_b;
    logic [PIXEL_BITS-1:0]      w_old_c;
    logic [PIXEL_BITS-1:0]      w_pri_c;
    logic [PIXEL_BITS-1:0]      w_pri_n;

    logic [cpcf_pkg::RES_N-1:0] w_res_valid;
    logic [PIXEL_BITS-1:0]      w_res_pix [cpcf_pkg::RES_N];
    cpcf_pkg::t_pos             w_res_pos [cpcf_pkg::RES_N];
    logic                       w_q_free;

    // Saturate the frame size into its legal range
    always_comb begin
        if (r_frame_rows == '0) begin
            w_rows = RCMP_W'(1);
        end else if (RCMP_W'(r_frame_rows) > ROWS_LIM) begin
            w_rows = ROWS_LIM;
        end else begin
            w_rows = RCMP_W'(r_frame_rows);
        end
        if (r_frame_cols == '0) begin
            w_cols = CCMP_W'(1);
        end else if (CCMP_W'(r_frame_cols) > COLS_LIM) begin
            w_cols = COLS_LIM;
        end else begin
            w_cols = CCMP_W'(r_frame_cols);
        end
    end

    // Qualify the neighbourhood of the pixel at the current position
    assign w_row_p1 = RCMP_W'(r_row_cnt) + RCMP_W'(1);
    assign w_col_p1 = CCMP_W'(r_col_cnt) + CCMP_W'(1);

    always_comb begin
        w_flags.r_ge1     = (r_row_cnt != '0);
        w_flags.r_ge2     = (RCMP_W'(r_row_cnt) >= RCMP_W'(2));
        w_flags.r_lt_rows = (RCMP_W'(r_row_cnt) < w_rows);
        w_flags.c_ge1     = (r_col_cnt != '0);
        w_flags.c_ge2     = (CCMP_W'(r_col_cnt) >= CCMP_W'(2));
        w_flags.row_end   = (w_col_p1 >= w_cols);
        w_flags.rt_ok     = !w_flags.row_end;
        w_flags.last_row  = (w_row_p1 >= w_rows);
    end

    // Advance the raster position on each accepted transaction
    always_comb begin
        n_row_cnt = r_row_cnt;
        n_col_cnt = r_col_cnt;
        if (w_in_acc) begin
            if (w_flags.row_end) begin
                n_col_cnt = '0;
                n_row_cnt = w_flags.last_row ? '0 : ROW_W'(w_row_p1);
            end else begin
                n_col_cnt = COL_W'(w_col_p1);
            end
        end
    end

    assign w_a_adv     = r_a_valid && w_q_free;
    assign i_pix.ready = !r_a_valid || w_a_adv;
    assign w_in_acc    = i_pix.valid && i_pix.ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= cpcf_pkg::CFG_W'(1);
            r_frame_cols <= cpcf_pkg::CFG_W'(1);
            r_row_cnt    <= '0;
            r_col_cnt    <= '0;
            r_a_valid    <= 1'b0;
            r_rec0       <= '0;
            r_rec1       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cpcf_pkg::REG_FRAME_ROWS: r_frame_rows <= i_cfg_data;
                    cpcf_pkg::REG_FRAME_COLS: r_frame_cols <= i_cfg_data;
                endcase
            end
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
            if (w_in_acc) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            // Shift the last two pixels of the row
            if (w_a_adv) begin
                r_rec1 <= r_rec0;
                r_rec0 <= r_a_pix;
            end
        end
    end

    // Load the input stage and note a write that lands on this read
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_flags <= w_flags;
            r_a_row   <= r_row_cnt;
            r_a_col   <= r_col_cnt;
            r_a_pix   <= i_pix.pixel_in;
            r_fwd_a   <= w_a_adv && (r_a_col == r_col_cnt);
            r_fwd_b   <= w_a_adv && (r_a_col == COL_W'(w_col_p1));
            r_fwd_old <= w_pri_c;
            r_fwd_pri <= r_a_pix;
        end
        if (w_a_adv) begin
            r_left <= w_pri_c;
        end
    end

    // Line buffers: {older row, prior row} per column
    cpcf_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (w_a_adv),
        .i_waddr   (r_a_col),
        .i_wdata   ({w_pri_c, r_a_pix}),
        .i_re      (w_in_acc),
        .i_raddr_a (r_col_cnt),
        .i_raddr_b (COL_W'(w_col_p1)),
        .o_rdata_a (w_ram_a),
        .o_rdata_b (w_ram_b)
    );

    assign w_old_c = r_fwd_a ? r_fwd_old : w_ram_a[2*PIXEL_BITS-1:PIXEL_BITS];
    assign w_pri_c = r_fwd_a ? r_fwd_pri : w_ram_a[PIXEL_BITS-1:0];
    assign w_pri_n = r_fwd_b ? r_fwd_pri : w_ram_b[PIXEL_BITS-1:0];

    cpcf_kernel #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_kernel (
        .i_flags (r_a_flags),
        .i_pix   (r_a_pix),
        .i_old_c (w_old_c),
        .i_pri_c (w_pri_c),
        .i_pri_n (w_pri_n),
        .i_left  (r_left),
        .i_rec0  (r_rec0),
        .i_rec1  (r_rec1),
        .o_valid (w_res_valid),
        .o_pix   (w_res_pix)
    );

    // Coordinates of each result slot
    always_comb begin
        w_res_pos[cpcf_pkg::SLOT_PREV].row       = cpcf_pkg::POS_W'(r_a_row - ROW_W'(1));
        w_res_pos[cpcf_pkg::SLOT_PREV].col       = cpcf_pkg::POS_W'(r_a_col);
        w_res_pos[cpcf_pkg::SLOT_PREV].frame_end = 1'b0;
        w_res_pos[cpcf_pkg::SLOT_LAG].row        = cpcf_pkg::POS_W'(r_a_row);
        w_res_pos[cpcf_pkg::SLOT_LAG].col        = cpcf_pkg::POS_W'(r_a_col - COL_W'(1));
        w_res_pos[cpcf_pkg::SLOT_LAG].frame_end  = 1'b0;
        w_res_pos[cpcf_pkg::SLOT_LAST].row       = cpcf_pkg::POS_W'(r_a_row);
        w_res_pos[cpcf_pkg::SLOT_LAST].col       = cpcf_pkg::POS_W'(r_a_col);
        w_res_pos[cpcf_pkg::SLOT_LAST].frame_end = 1'b1;
    end

    cpcf_outq #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_a_adv),
        .i_valid (w_res_valid),
        .i_pos   (w_res_pos),
        .i_pix   (w_res_pix),
        .o_free  (w_q_free),
        .o_res   (o_res)
    );

    // The frame's final pixel leaves the position counters at the frame start
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_flags.last_row && r_a_flags.row_end)
            |-> (r_row_cnt == '0 && r_col_cnt == '0))
        else $error("position counters not at frame start after final pixel");

    // An accepted transaction always occupies the input stage next
    a_stage_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_a_valid)
        else $error("accepted pixel lost from input stage");

    // A blocked input stage keeps its pixel and position
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_a_adv)
            |=> (r_a_valid && $stable(r_a_col) && $stable(r_a_pix)))
        else $error("input stage changed while blocked");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cross_peak_clip_filter: frames of pixels in, clipped results out.
// Depends on cpcf_pkg, the cpcf_pix_if/cpcf_res_if interfaces and the filter RTL in hdl/.
module tb;

    localparam int PIX_W                = 16;
    localparam int LINE_MAX             = 1024;
    localparam int DRAIN_CYCLES         = 8;
    localparam int TARGET_RANDOM_PIXELS = 300;
    localparam int REPORT_LIMIT         = 20;
    localparam longint TIMEOUT_NS       = 40_000_000;

    typedef enum int {PACE_FULL, PACE_JITTER, PACE_BURSTY} t_pace;
    typedef enum int {TONE_FULL, TONE_LOW, TONE_EDGE} t_tone;

    typedef struct packed {
        logic [cpcf_pkg::POS_W-1:0] row;
        logic [cpcf_pkg::POS_W-1:0] col;
        logic [PIX_W-1:0]           value;
        logic                       fend;
    } t_clip_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [cpcf_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [cpcf_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           sink_ready = 1'b0;

    cpcf_pix_if #(.PIXEL_BITS(PIX_W)) pix_ch ();
    cpcf_res_if #(.PIXEL_BITS(PIX_W)) res_ch ();

    assign res_ch.ready = sink_ready;

    cross_peak_clip_filter #(
        .MAX_COLS  (LINE_MAX),
        .MAX_ROWS  (LINE_MAX),
        .PIXEL_BITS(PIX_W)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix     (pix_ch),
        .o_res     (res_ch)
    );

    // Predictor state: line buffers, position and the last two pixels of the row
    logic [PIX_W-1:0]           older_line [LINE_MAX];
    logic [PIX_W-1:0]           prior_line [LINE_MAX];
    logic [PIX_W-1:0]           recent_px  [2];
    int unsigned                row_pos;
    int unsigned                col_pos;
    logic [cpcf_pkg::CFG_W-1:0] cfg_rows;
    logic [cpcf_pkg::CFG_W-1:0] cfg_cols;

    t_clip_result clip_due [$];

    t_pace src_pace   = PACE_JITTER;
    t_pace sink_pace  = PACE_JITTER;
    t_tone tone       = TONE_FULL;
    int    stall_left = 0;
    int    mismatches = 0;
    int    pixels_in  = 0;
    int    results_out = 0;
    int    frames_out = 0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Saturate a size register into 1..LINE_MAX
    function automatic int unsigned size_in_range(input logic [cpcf_pkg::CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > LINE_MAX) return LINE_MAX;
        return 32'(v);
    endfunction

    // Clip to the largest non-zero neighbour when strictly above it
    function automatic logic [PIX_W-1:0] peak_clip(input logic [PIX_W-1:0] centre, up, dn, lf, rt);
        logic [PIX_W-1:0] top;
        top = up;
        if (dn > top) top = dn;
        if (lf > top) top = lf;
        if (rt > top) top = rt;
        return (top != '0 && centre > top) ? top : centre;
    endfunction

    function automatic void add_due(input logic [cpcf_pkg::POS_W-1:0] row, col,
                                    input logic [PIX_W-1:0] value, input logic fend);
        t_clip_result item;
        item.row   = row;
        item.col   = col;
        item.value = value;
        item.fend  = fend;
        clip_due   = {clip_due, item};
    endfunction

    // Work out the results caused by one accepted pixel and advance the position
    function automatic void predict_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      rows, cols, r, c;
        bit               row_end, last_row;
        logic [PIX_W-1:0] up, dn, lf, rt;
        rows     = size_in_range(cfg_rows);
        cols     = size_in_range(cfg_cols);
        r        = row_pos;
        c        = col_pos;
        row_end  = (c + 1 >= cols);
        last_row = (r + 1 >= rows);

        // Emit the pixel of the row above now that its lower neighbour is known
        if (r >= 1) begin
            up = (r >= 2) ? older_line[c] : '0;
            dn = (r < rows) ? pix : '0;
            lf = (c >= 1) ? older_line[c - 1] : '0;
            rt = (c + 1 < cols) ? prior_line[c + 1] : '0;
            add_due(cpcf_pkg::POS_W'(r - 1), cpcf_pkg::POS_W'(c),
                    peak_clip(prior_line[c], up, dn, lf, rt), 1'b0);
        end

        older_line[c] = prior_line[c];
        prior_line[c] = pix;

        // On the last row emit one column back, and flush the final pixel
        if (last_row) begin
            if (c >= 1) begin
                up = (r >= 1) ? older_line[c - 1] : '0;
                lf = (c >= 2) ? recent_px[1] : '0;
                add_due(cpcf_pkg::POS_W'(r), cpcf_pkg::POS_W'(c - 1),
                        peak_clip(recent_px[0], up, '0, lf, pix), 1'b0);
            end
            if (row_end) begin
                up = (r >= 1) ? older_line[c] : '0;
                lf = (c >= 1) ? recent_px[0] : '0;
                add_due(cpcf_pkg::POS_W'(r), cpcf_pkg::POS_W'(c),
                        peak_clip(pix, up, '0, lf, '0), 1'b1);
            end
        end

        recent_px[1] = recent_px[0];
        recent_px[0] = pix;

        if (row_end) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic int source_gap();
        int pick;
        case (src_pace)
            PACE_FULL: return 0;
            PACE_JITTER: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
            default: begin
                pick = int'($urandom_range(0, 99));
                if (pick < 70) return 0;
                if (pick < 95) return int'($urandom_range(1, 3));
                return int'($urandom_range(10, 40));
            end
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case (tone)
            TONE_LOW: return PIX_W'($urandom_range(0, 3));
            TONE_EDGE: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return PIX_W'(1);
                    2: return 16'hFFFE;
                    3: return 16'hFFFF;
                    default: return PIX_W'($urandom);
                endcase
            end
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Send one pixel after a random gap and predict its results on acceptance
    task automatic push_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= value;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        predict_pixel(value);
        pixels_in++;
    endtask

    // Hold the source idle until every expected result has arrived, then let the pipe empty
    task automatic settle_pipeline();
        pix_ch.valid <= 1'b0;
        while (clip_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both size registers; only called while the block is idle
    task automatic load_frame_size(input logic [cpcf_pkg::CFG_W-1:0] rows_w, cols_w);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= cpcf_pkg::REG_FRAME_ROWS;
        i_cfg_data <= rows_w;
        @(posedge i_clk);
        i_cfg_idx  <= cpcf_pkg::REG_FRAME_COLS;
        i_cfg_data <= cols_w;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_rows = rows_w;
        cfg_cols = cols_w;
    endtask

    task automatic send_frame(input logic [cpcf_pkg::CFG_W-1:0] rows_w, cols_w,
                              input logic [PIX_W-1:0] px [$]);
        settle_pipeline();
        load_frame_size(rows_w, cols_w);
        foreach (px[i]) push_pixel(px[i]);
    endtask

    // Send pixels until the frame wraps; optionally shrink a size mid-frame
    task automatic run_frame(input int shrink_at);
        int n;
        n = 0;
        do begin
            if (n == shrink_at) begin
                settle_pipeline();
                if ($urandom_range(0, 1) == 0)
                    load_frame_size(cpcf_pkg::CFG_W'($urandom_range(1, row_pos + 1)), cfg_cols);
                else
                    load_frame_size(cfg_rows, cpcf_pkg::CFG_W'($urandom_range(1, col_pos + 1)));
            end else if ($urandom_range(0, 49) == 0) begin
                settle_pipeline();
            end
            push_pixel(pick_pixel());
            n++;
        end while (row_pos != 0 || col_pos != 0);
    endtask

    // Reset sizes, field extremes, ties, zero neighbours and single-column frames
    task automatic test_directed();
        src_pace  = PACE_JITTER;
        sink_pace = PACE_JITTER;
        // after reset each pixel is a 1x1 frame of its own
        push_pixel(16'h0000);
        push_pixel(16'hFFFF);
        push_pixel(16'h8001);
        send_frame(3, 4, '{16'h0000, 16'hFFFF, 16'h0005, 16'h0005,
                           16'h0007, 16'h0003, 16'hFFFF, 16'h0000,
                           16'h0001, 16'h8000, 16'h0002, 16'hFFFF});
        // no counting neighbour: pixels pass unchanged
        send_frame(1, 3, '{16'h5555, 16'h0000, 16'hAAAA});
        send_frame(2, 1, '{16'h00FF, 16'hFF00});
    endtask

    // Zero, largest and oversize values of both size registers; large frames are cut short
    task automatic test_size_limits();
        logic [cpcf_pkg::CFG_W-1:0] rows_set [3] = '{11'd0, 11'd0, 11'd3};
        logic [cpcf_pkg::CFG_W-1:0] cols_set [3] = '{11'd0, 11'd5, 11'd0};
        src_pace  = PACE_JITTER;
        sink_pace = PACE_JITTER;
        tone      = TONE_FULL;
        foreach (rows_set[i]) begin
            settle_pipeline();
            load_frame_size(rows_set[i], cols_set[i]);
            run_frame(-1);
        end
        // oversize width and height: run part of row 0, then end the frame
        settle_pipeline();
        load_frame_size(11'd2047, 11'd2047);
        repeat (12) push_pixel(pick_pixel());
        settle_pipeline();
        load_frame_size(11'd1, 11'd13);
        run_frame(-1);
        // largest legal sizes
        settle_pipeline();
        load_frame_size(11'd1024, 11'd1024);
        repeat (9) push_pixel(pick_pixel());
        settle_pipeline();
        load_frame_size(11'd1, 11'd10);
        run_frame(-1);
        // oversize height over ten narrow rows, then end it
        settle_pipeline();
        load_frame_size(11'd2047, 11'd2);
        repeat (20) push_pixel(pick_pixel());
        settle_pipeline();
        load_frame_size(11'd11, 11'd2);
        run_frame(-1);
    endtask

    // Shrink and grow both sizes part way through a frame
    task automatic test_resize_midframe();
        src_pace  = PACE_BURSTY;
        sink_pace = PACE_BURSTY;
        tone      = TONE_LOW;
        // fill the first eight columns of both line buffers
        settle_pipeline();
        load_frame_size(3, 8);
        run_frame(-1);
        // narrow the width inside row 2, then cut the height below the current row
        settle_pipeline();
        load_frame_size(4, 6);
        repeat (15) push_pixel(pick_pixel());
        settle_pipeline();
        load_frame_size(4, 3);
        repeat (2) push_pixel(pick_pixel());
        settle_pipeline();
        load_frame_size(2, 3);
        run_frame(-1);
        // widen inside row 1, then add a row
        settle_pipeline();
        load_frame_size(3, 4);
        repeat (6) push_pixel(pick_pixel());
        settle_pipeline();
        load_frame_size(3, 7);
        repeat (5) push_pixel(pick_pixel());
        settle_pipeline();
        load_frame_size(4, 7);
        run_frame(-1);
    endtask

    // Random frames: mostly small, some wide, some tall, a few resized mid-frame
    task automatic test_random_frames();
        int                         start_count, pick, frame_px, shrink_at;
        logic [cpcf_pkg::CFG_W-1:0] rows_w, cols_w;
        start_count = pixels_in;
        while (pixels_in - start_count < TARGET_RANDOM_PIXELS) begin
            src_pace  = t_pace'($urandom_range(0, 2));
            sink_pace = t_pace'($urandom_range(0, 2));
            tone      = t_tone'($urandom_range(0, 2));
            if (pixels_in == start_count || $urandom_range(0, 9) < 7) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 75) begin
                    rows_w = cpcf_pkg::CFG_W'($urandom_range(1, 5));
                    cols_w = cpcf_pkg::CFG_W'($urandom_range(1, 8));
                end else if (pick < 90) begin
                    rows_w = cpcf_pkg::CFG_W'($urandom_range(1, 3));
                    cols_w = cpcf_pkg::CFG_W'($urandom_range(9, 48));
                end else begin
                    rows_w = cpcf_pkg::CFG_W'($urandom_range(6, 14));
                    cols_w = cpcf_pkg::CFG_W'($urandom_range(1, 3));
                end
                if ($urandom_range(0, 19) == 0) rows_w = '0;
                if ($urandom_range(0, 19) == 0) cols_w = '0;
                settle_pipeline();
                load_frame_size(rows_w, cols_w);
            end
            frame_px  = int'(size_in_range(cfg_rows) * size_in_range(cfg_cols));
            shrink_at = -1;
            if ($urandom_range(0, 5) == 0) shrink_at = int'($urandom_range(0, frame_px - 1));
            run_frame(shrink_at);
        end
    endtask

    // Result sink: ready pattern follows the current pace
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end else begin
            case (sink_pace)
                PACE_FULL: sink_ready <= 1'b1;
                PACE_JITTER: sink_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 24) == 0) begin
                        stall_left <= int'($urandom_range(8, 30));
                        sink_ready <= 1'b0;
                    end else begin
                        sink_ready <= ($urandom_range(0, 5) != 0);
                    end
                end
            endcase
        end
    end

    // Compare each result transaction with the oldest expected one
    always @(posedge i_clk) begin : result_check
        t_clip_result due;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (clip_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result row %0d col %0d value %h",
                                          res_ch.out_row, res_ch.out_col, res_ch.pixel_out));
            end else begin
                due = clip_due.pop_front();
                if (res_ch.out_row !== due.row)
                    report_mismatch($sformatf("row %0d, want %0d", res_ch.out_row, due.row));
                if (res_ch.out_col !== due.col)
                    report_mismatch($sformatf("col %0d, want %0d at row %0d",
                                              res_ch.out_col, due.col, due.row));
                if (res_ch.pixel_out !== due.value)
                    report_mismatch($sformatf("value %h, want %h at (%0d,%0d)",
                                              res_ch.pixel_out, due.value, due.row, due.col));
                if (res_ch.frame_end !== due.fend)
                    report_mismatch($sformatf("frame_end %b, want %b at (%0d,%0d)",
                                              res_ch.frame_end, due.fend, due.row, due.col));
                results_out++;
                if (due.fend) frames_out++;
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= cpcf_pkg::REG_FRAME_ROWS;
        i_cfg_data      <= '0;
        pix_ch.valid    <= 1'b0;
        pix_ch.pixel_in <= '0;
        older_line = '{default: '0};
        prior_line = '{default: '0};
        recent_px  = '{default: '0};
        row_pos    = 0;
        col_pos    = 0;
        cfg_rows   = 1;
        cfg_cols   = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_size_limits();
        test_resize_midframe();
        test_random_frames();

        settle_pipeline();
        repeat (24) @(posedge i_clk);
        $display("Sent %0d pixels; checked %0d results over %0d frames.",
                 pixels_in, results_out, frames_out);
        $display("Covered hand-set frames, size saturation, mid-frame resizing and random frames.");
        if (mismatches == 0) begin
            $display("cross_peak_clip_filter test passed");
        end else begin
            $display("cross_peak_clip_filter test failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("cross_peak_clip_filter test failed");
        $finish;
    end

endmodule

>>> cross_peak_clip_filter.f
hdl/cpcf_pkg.sv
hdl/cpcf_if.sv
hdl/cpcf_ram.sv
hdl/cpcf_kernel.sv
hdl/cpcf_outq.sv
hdl/cross_peak_clip_filter.sv
verif/tb.sv
